[rtl/core/bale_pkg.sv]
`timescale 1ns / 1ps

package bale_pkg;

	// command codes
	localparam logic [2:0] CMD_READ   = 3'd0;
	localparam logic [2:0] CMD_WRITE  = 3'd1;
	localparam logic [2:0] CMD_APPEND = 3'd2;
	localparam logic [2:0] CMD_INSERT = 3'd3;
	localparam logic [2:0] CMD_REMOVE = 3'd4;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_INDEX = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	// fixed field widths
	localparam int CMD_W    = 3;
	localparam int POS_W    = 8;
	localparam int VAL_W    = 32;
	localparam int LEN_W    = 9;
	localparam int STAT_W   = 2;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_MV,
		S_TAIL,
		S_RESP
	} state_t;

	// controls for the index stepper
	typedef struct packed {
		logic load;
		logic adv;
		logic up;
	} step_ctrl_t;

endpackage

[rtl/core/bounded_array_list_engine_unit.sv]
`timescale 1ns / 1ps

// Bounded array list: an ordered store of up to CAPACITY elements with a
// running count. Each input transfer carries a command (read, write, append,
// insert before position, remove at position) and gives exactly one output
// transfer with the read value (zero unless a good read), the count after the
// command and a status (ok, bad index, store full). A failed command changes
// nothing. The elements live in one single-port memory with a registered
// read; insert and remove move elements one at a time through that port, a
// read and a write per moved element, walked by one shared index stepper.
// The block takes a new input only while idle, but a finished result may
// wait in the output register while the next command is accepted. No
// clearing pass is needed after reset: only entries below the count are
// ever read.

module bounded_array_list_engine_unit import bale_pkg::*; #(
	parameter int CAPACITY = 256,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// command[2:0], position[10:3], value[42:11], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// read_value[31:0], length[40:32], status[42:41], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready
);

	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;
	localparam int EW   = ELEMENT_WIDTH;

	// input field unpack
	logic [CMD_W-1:0]        cmd;
	logic [POS_W-1:0]        pos;
	logic signed [VAL_W-1:0] value;
	assign cmd   = s_tdata[CMD_W-1:0];
	assign pos   = s_tdata[CMD_W+POS_W-1:CMD_W];
	assign value = s_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W];

	state_t state_q, state_d;

	logic [CW-1:0]     count_q;
	logic [CW-1:0]     count_d;
	logic [STAT_W-1:0] status_d, status_q;
	logic              rdsel_q;
	logic              ins_q;
	logic [EW-1:0]     carry_q;

	logic              accept;
	logic              pos_ok;
	logic              full;
	logic [AW-1:0]     pos_a;
	logic [AW-1:0]     cnt_a;
	logic [AW-1:0]     last_a;
	logic [63:0]       val64;
	logic [EW-1:0]     val_e;

	logic              mem_en, mem_we;
	logic [AW-1:0]     mem_addr;
	logic [EW-1:0]     mem_wdata, mem_rdata;

	step_ctrl_t        sctl;
	logic [AW-1:0]     idx;
	logic              at_end;
	logic [AW-1:0]     load_idx, end_idx;

	logic              out_free, out_load;
	logic [63:0]       rd_ext;
	logic [VAL_W-1:0]  rv_q;
	logic [LEN_W-1:0]  len_q;
	logic [STAT_W-1:0] st_q;
	logic              mvalid_q;

	assign accept = s_tvalid && s_tready;
	assign pos_ok = CMPW'(pos) < CMPW'(count_q);
	assign full   = (count_q == CW'(CAPACITY));
	assign pos_a  = AW'(pos);
	assign cnt_a  = AW'(count_q);
	assign last_a = AW'(count_q - CW'(1));

	// input value is sign-extended, then kept to the element width
	assign val64 = {{(64 - VAL_W){value[VAL_W-1]}}, value};
	assign val_e = val64[EW-1:0];

	// status and new count for the command being accepted
	always_comb begin
		status_d = STAT_OK;
		count_d  = count_q;
		case (cmd)
			CMD_READ, CMD_WRITE: begin
				if (!pos_ok) begin
					status_d = STAT_BAD_INDEX;
				end
			end
			CMD_APPEND: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			CMD_INSERT: begin
				if (!pos_ok) begin
					status_d = STAT_BAD_INDEX;
				end else if (full) begin
					status_d = STAT_FULL;
				end else begin
					count_d = count_q + CW'(1);
				end
			end
			CMD_REMOVE: begin
				if (!pos_ok) begin
					status_d = STAT_BAD_INDEX;
				end else begin
					count_d = count_q - CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// insert walks up from position to count-1, remove walks down to position
	assign load_idx = (cmd == CMD_INSERT) ? pos_a : last_a;
	assign end_idx  = (cmd == CMD_INSERT) ? last_a : pos_a;

	assign out_free = !mvalid_q || m_tready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if ((cmd inside {CMD_INSERT, CMD_REMOVE}) && status_d == STAT_OK) begin
						state_d = S_RD;
					end else begin
						state_d = S_RESP;
					end
				end
			end
			S_RD: state_d = S_MV;
			S_MV: begin
				if (!at_end) begin
					state_d = S_RD;
				end else if (ins_q) begin
					state_d = S_TAIL;
				end else begin
					state_d = S_RESP;
				end
			end
			S_TAIL: state_d = S_RESP;
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = idx;
		mem_wdata = carry_q;
		sctl      = '{load: 1'b0, adv: 1'b0, up: ins_q};
		s_tready  = 1'b0;
		out_load  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready  = 1'b1;
				mem_addr  = (cmd == CMD_APPEND) ? cnt_a : pos_a;
				mem_wdata = val_e;
				sctl.load = accept;
				if (accept && status_d == STAT_OK) begin
					if (cmd inside {CMD_READ, CMD_WRITE, CMD_APPEND}) begin
						mem_en = 1'b1;
						mem_we = (cmd != CMD_READ);
					end
				end
			end
			S_RD: begin
				mem_en = 1'b1;
			end
			S_MV: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				sctl.adv = 1'b1;
			end
			S_TAIL: begin
				mem_en = 1'b1;
				mem_we = 1'b1;
			end
			S_RESP: begin
				out_load = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				count_q <= count_d;
			end
		end
	end

	// per-command working registers, carry holds the element in flight
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			rdsel_q  <= (cmd == CMD_READ) && pos_ok;
			ins_q    <= (cmd == CMD_INSERT);
			carry_q  <= val_e;
		end else if (state_q == S_MV) begin
			carry_q <= mem_rdata;
		end
	end

	bale_ram #(
		.DEPTH(CAPACITY),
		.AW(AW),
		.DW(EW)
	) u_ram (
		.clk(clk),
		.en(mem_en),
		.we(mem_we),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	bale_step #(
		.AW(AW)
	) u_step (
		.clk(clk),
		.ctrl(sctl),
		.load_idx(load_idx),
		.end_idx(end_idx),
		.idx(idx),
		.at_end(at_end)
	);

	// read data is sign-extended from the element width
	always_comb begin
		rd_ext = {64{mem_rdata[EW-1]}};
		rd_ext[EW-1:0] = mem_rdata;
	end

	// output register, parts the result side from the command side
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mvalid_q <= 1'b0;
		end else if (out_load) begin
			mvalid_q <= 1'b1;
		end else if (m_tready) begin
			mvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rv_q  <= rdsel_q ? rd_ext[VAL_W-1:0] : '0;
			len_q <= LEN_W'(count_q);
			st_q  <= status_q;
		end
	end

	assign m_tvalid = mvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - VAL_W - LEN_W - STAT_W){1'b0}}, st_q, len_q, rv_q};

	// count never goes past the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("element count above capacity");

	// one command moves the count by at most one
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1)) ||
			(count_q == $past(count_q) - CW'(1)))
		else $error("count changed by more than one");

	// the shift walk stays inside the store
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MV || state_q == S_TAIL) |-> (CW'(idx) < CW'(CAPACITY)))
		else $error("shift index outside the store");

	// no new command while the shift is reading or moving elements
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD || state_q == S_MV) |-> !s_tready)
		else $error("input ready during shift");

endmodule

[rtl/core/bale_ram.sv]
`timescale 1ns / 1ps

module bale_ram #(
	parameter int DEPTH = 256,
	parameter int AW = 8,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          en,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [DW-1:0] wdata,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	// single port, registered read, read data held while idle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/core/bale_step.sv]
`timescale 1ns / 1ps

module bale_step import bale_pkg::*; #(
	parameter int AW = 8
) (
	input  logic          clk,
	input  step_ctrl_t    ctrl,
	input  logic [AW-1:0] load_idx,
	input  logic [AW-1:0] end_idx,
	output logic [AW-1:0] idx,
	output logic          at_end
);

	logic [AW-1:0] idx_q;
	logic [AW-1:0] end_q;

	// one shared incrementer/decrementer walks the shift window
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			idx_q <= load_idx;
			end_q <= end_idx;
		end else if (ctrl.adv) begin
			idx_q <= ctrl.up ? idx_q + AW'(1) : idx_q - AW'(1);
		end
	end

	assign idx    = idx_q;
	assign at_end = (idx_q == end_q);

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
	import bale_pkg::*;

	localparam int LIST_CAP = 256;
	// spare command codes, the block must treat them as no-ops
	localparam logic [2:0] CMD_SPARE_5 = 3'd5;
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	localparam int RANDOM_ITEMS = 1050;
	localparam int STALL_LIMIT  = 4000;

	typedef struct packed {
		logic [VAL_W-1:0]  rd;
		logic [LEN_W-1:0]  len;
		logic [STAT_W-1:0] st;
	} list_reply_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		bit               typed;
		list_reply_t      reply;
	} dir_row_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;

	// shadow copy of the list
	logic [VAL_W-1:0] shadow_list [LIST_CAP];
	int               shadow_len = 0;

	list_reply_t replies_due [$];
	dir_row_t    dir_rows [$];
	int          err_count = 0;
	int          quiet_cycles = 0;
	bit          idle_on = 1'b1;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	bounded_array_list_engine_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	// applies one command to the shadow list and gives the reply it must produce
	function automatic list_reply_t apply_list_op(input logic [CMD_W-1:0] cmd,
			input logic [POS_W-1:0] pos, input logic [VAL_W-1:0] val);
		list_reply_t r;
		bit          in_range;
		int          i;
		r = '0;
		in_range = int'(pos) < shadow_len;
		case (cmd)
			CMD_READ: begin
				if (in_range) r.rd = shadow_list[pos];
				else r.st = STAT_BAD_INDEX;
			end
			CMD_WRITE: begin
				if (in_range) shadow_list[pos] = val;
				else r.st = STAT_BAD_INDEX;
			end
			CMD_APPEND: begin
				if (shadow_len < LIST_CAP) begin
					shadow_list[shadow_len] = val;
					shadow_len++;
				end else begin
					r.st = STAT_FULL;
				end
			end
			CMD_INSERT: begin
				// index check wins over the full check
				if (!in_range) begin
					r.st = STAT_BAD_INDEX;
				end else if (shadow_len >= LIST_CAP) begin
					r.st = STAT_FULL;
				end else begin
					for (i = shadow_len; i > int'(pos); i--)
						shadow_list[i] = shadow_list[i-1];
					shadow_list[pos] = val;
					shadow_len++;
				end
			end
			CMD_REMOVE: begin
				if (in_range) begin
					for (i = int'(pos); i + 1 < shadow_len; i++)
						shadow_list[i] = shadow_list[i+1];
					shadow_len--;
				end else begin
					r.st = STAT_BAD_INDEX;
				end
			end
			default: ;
		endcase
		r.len = shadow_len[LEN_W-1:0];
		return r;
	endfunction

	task automatic add_row(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val, input bit typed, input logic [VAL_W-1:0] rd,
			input logic [LEN_W-1:0] len, input logic [STAT_W-1:0] st);
		dir_row_t row;
		row.cmd = cmd;
		row.pos = pos;
		row.val = val;
		row.typed = typed;
		row.reply.rd = rd;
		row.reply.len = len;
		row.reply.st = st;
		dir_rows.push_back(row);
	endtask

	// one input transfer; the reply is booked at the accepting edge
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
			input logic [VAL_W-1:0] val, input bit typed, input list_reply_t typed_reply);
		list_reply_t predicted;
		while (idle_on && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, val, pos, cmd};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = apply_list_op(cmd, pos, val);
		replies_due.push_back(typed ? typed_reply : predicted);
	endtask

	// command mix per phase: grow to full, hover at full, then drain
	task automatic pick_cmd(input int phase, output logic [CMD_W-1:0] cmd,
			output logic [POS_W-1:0] pos, output logic [VAL_W-1:0] val);
		int roll;
		roll = $urandom_range(99);
		case (phase)
			0: cmd = roll < 55 ? CMD_APPEND : roll < 72 ? CMD_INSERT : roll < 82 ? CMD_READ :
				roll < 90 ? CMD_WRITE : roll < 95 ? CMD_REMOVE : 3'($urandom_range(7));
			1: cmd = roll < 25 ? CMD_APPEND : roll < 45 ? CMD_INSERT : roll < 65 ? CMD_READ :
				roll < 80 ? CMD_WRITE : roll < 90 ? CMD_REMOVE : 3'($urandom_range(7));
			default: cmd = roll < 60 ? CMD_REMOVE : roll < 70 ? CMD_APPEND :
				roll < 78 ? CMD_INSERT : roll < 88 ? CMD_READ : roll < 95 ? CMD_WRITE :
				3'($urandom_range(7));
		endcase
		// mostly good positions, some at the boundary, some anywhere
		roll = $urandom_range(19);
		if (shadow_len > 0 && roll > 2) pos = POS_W'($urandom_range(shadow_len - 1));
		else if (roll == 2 && shadow_len < LIST_CAP) pos = POS_W'(shadow_len);
		else pos = POS_W'($urandom_range(255));
		if ($urandom_range(15) == 0) begin
			case ($urandom_range(3))
				0: val = 32'h8000_0000;
				1: val = 32'h7fff_ffff;
				2: val = 32'h0000_0000;
				default: val = 32'hffff_ffff;
			endcase
		end else begin
			val = $urandom;
		end
	endtask

	// result side stalls at random, except inside the no-idle stretch
	always @(posedge clk)
		m_tready <= idle_on ? ($urandom_range(99) >= 31) : 1'b1;

	// compare each result transfer with the oldest booked reply
	always @(posedge clk) begin
		list_reply_t want;
		list_reply_t got;
		if (m_tvalid && m_tready) begin
			got.rd  = m_tdata[31:0];
			got.len = m_tdata[40:32];
			got.st  = m_tdata[42:41];
			if (replies_due.size() == 0) begin
				$display("%0t unexpected result: expected none, actual rd=%h len=%0d st=%0d",
					$time, got.rd, got.len, got.st);
				err_count++;
			end else begin
				want = replies_due.pop_front();
				if (got.rd !== want.rd) begin
					$display("%0t read_value: expected %h, actual %h", $time, want.rd, got.rd);
					err_count++;
				end
				if (got.len !== want.len) begin
					$display("%0t length: expected %0d, actual %0d", $time, want.len, got.len);
					err_count++;
				end
				if (got.st !== want.st) begin
					$display("%0t status: expected %0d, actual %0d", $time, want.st, got.st);
					err_count++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
			$display("tb: errors");
			$finish;
		end
	end

	initial begin
		logic [CMD_W-1:0] cmd;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] val;
		int               phase;
		// empty list: everything indexed fails
		add_row(CMD_READ,    8'd0,   32'h0000_0000, 1, 32'h0, 9'd0, STAT_BAD_INDEX);
		add_row(CMD_WRITE,   8'd0,   32'h0000_0005, 1, 32'h0, 9'd0, STAT_BAD_INDEX);
		add_row(CMD_INSERT,  8'd0,   32'h0000_0007, 1, 32'h0, 9'd0, STAT_BAD_INDEX);
		add_row(CMD_REMOVE,  8'd0,   32'h0000_0000, 1, 32'h0, 9'd0, STAT_BAD_INDEX);
		// value extremes
		add_row(CMD_APPEND,  8'd0,   32'h8000_0000, 1, 32'h0, 9'd1, STAT_OK);
		add_row(CMD_APPEND,  8'd255, 32'h7fff_ffff, 1, 32'h0, 9'd2, STAT_OK);
		add_row(CMD_READ,    8'd0,   32'h0000_0000, 1, 32'h8000_0000, 9'd2, STAT_OK);
		add_row(CMD_READ,    8'd1,   32'hffff_ffff, 1, 32'h7fff_ffff, 9'd2, STAT_OK);
		// position equal to count is out of range, insert too
		add_row(CMD_READ,    8'd2,   32'h0000_0000, 1, 32'h0, 9'd2, STAT_BAD_INDEX);
		add_row(CMD_INSERT,  8'd2,   32'h0000_0001, 1, 32'h0, 9'd2, STAT_BAD_INDEX);
		add_row(CMD_INSERT,  8'd0,   32'hffff_ffff, 1, 32'h0, 9'd3, STAT_OK);
		add_row(CMD_READ,    8'd0,   32'h0000_0000, 1, 32'hffff_ffff, 9'd3, STAT_OK);
		add_row(CMD_WRITE,   8'd2,   32'h0000_0000, 0, 32'h0, 9'd0, STAT_OK);
		add_row(CMD_INSERT,  8'd1,   32'h1234_5678, 0, 32'h0, 9'd0, STAT_OK);
		add_row(CMD_READ,    8'd3,   32'h0000_0000, 0, 32'h0, 9'd0, STAT_OK);
		add_row(CMD_REMOVE,  8'd0,   32'h0000_0000, 0, 32'h0, 9'd0, STAT_OK);
		add_row(CMD_REMOVE,  8'd255, 32'h0000_0000, 1, 32'h0, 9'd3, STAT_BAD_INDEX);
		add_row(CMD_READ,    8'd255, 32'h0000_0000, 1, 32'h0, 9'd3, STAT_BAD_INDEX);
		// spare codes change nothing
		add_row(CMD_SPARE_5, 8'd0,   32'hffff_ffff, 1, 32'h0, 9'd3, STAT_OK);
		add_row(CMD_SPARE_6, 8'd1,   32'h8000_0000, 1, 32'h0, 9'd3, STAT_OK);
		add_row(CMD_SPARE_7, 8'd255, 32'h7fff_ffff, 1, 32'h0, 9'd3, STAT_OK);
		// remove the last element, then refill
		add_row(CMD_REMOVE,  8'd2,   32'h0000_0000, 0, 32'h0, 9'd0, STAT_OK);
		add_row(CMD_APPEND,  8'd0,   32'ha5a5_a5a5, 0, 32'h0, 9'd0, STAT_OK);
		add_row(CMD_READ,    8'd2,   32'h0000_0000, 0, 32'h0, 9'd0, STAT_OK);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k])
			send_cmd(dir_rows[k].cmd, dir_rows[k].pos, dir_rows[k].val, dir_rows[k].typed,
				dir_rows[k].reply);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			phase = n < 450 ? 0 : n < 600 ? 1 : 2;
			idle_on = !(n >= 300 && n < 420);
			pick_cmd(phase, cmd, pos, val);
			send_cmd(cmd, pos, val, 0, '0);
		end
		s_tvalid <= 1'b0;
		idle_on = 1'b1;

		while (replies_due.size() != 0) @(posedge clk);
		// a longest shift, in case a stray result is still on its way
		repeat (600) @(posedge clk);
		if (err_count == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule

[bounded_array_list_engine_unit.f]
rtl/core/bale_pkg.sv
rtl/core/bale_ram.sv
rtl/core/bale_step.sv
rtl/core/bounded_array_list_engine_unit.sv
dv/tb.sv
